FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: hw/rtl/lphm_pkg.sv
// ---------------------------------------------------------------------------
// lphm_pkg
// Shared types and codes for the linear probing hash map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package lphm_pkg;
  localparam int TABLE_DEPTH = 256;

  localparam logic [1:0] MODE_GET = 2'd0;
  localparam logic [1:0] MODE_PUT = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  typedef struct packed {
    logic load;      // capture request
    logic hash_step; // fold one key byte
    logic div_init;  // start modulo
    logic div_step;  // one remainder bit
    logic rd;        // issue slot read
    logic advance;   // next probe slot
    logic wr_fill;   // write key/value, occupied
    logic wr_upd;    // write value
    logic wr_del;    // mark deleted
    logic finish;    // emit result
    logic set_full;  // status full
    logic set_miss;  // status miss
  } lphm_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic div_last;
    logic probe_last;
    logic [1:0] slot_st;
    logic key_eq;
    logic [1:0] mode;
  } lphm_sts_t;
endpackage

FILE: hw/rtl/lphm_ram.sv
// ---------------------------------------------------------------------------
// lphm_ram
// Single-port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module lphm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/lphm_datapath.sv
// ---------------------------------------------------------------------------
// lphm_datapath
// Key hash, serial modulo, probe index, slot stores and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lphm_datapath #(
  parameter int KEY_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata,
  input  logic [1:0]        in_mode,
  input  logic [63:0]       in_key,
  input  logic [63:0]       in_value_in,
  input  lphm_pkg::lphm_cmd_t cmd,
  output lphm_pkg::lphm_sts_t sts,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [63:0]       out_value_out,
  output logic [8:0]        out_entry_count
);
  localparam int DEPTH = lphm_pkg::TABLE_DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;
  localparam int BW = $clog2(KEY_BYTES + 1);
  localparam int DW = $clog2(64 + 1);

  logic [8:0]    size_cfg_r;
  logic [SW-1:0] size_r, size_nxt;
  logic [1:0]    mode_r;
  logic [63:0]   key_r, val_r, hash_r, shreg_r;
  logic [BW-1:0] byte_r;
  logic          key_end_r;
  logic [SW-1:0] rem_r;
  logic [DW-1:0] bit_r;
  logic [AW-1:0] idx_r;
  logic [SW-1:0] probes_r;
  logic [8:0]    count_r, count_nxt;
  logic [DEPTH-1:0] st_valid_r;
  logic          vld_rd_r;
  logic [1:0]    st_rd;
  logic          st_we;
  logic [1:0]    st_wdata;
  logic [63:0]   key_rd, val_rd;
  logic [63:0]   norm_key;
  logic          hit_zero;
  logic [7:0]    cur_byte;
  logic [SW:0]   rem_sh;
  logic          key_we, val_we;
  logic [63:0]   val_wdata;

  always_comb begin
    norm_key = '0;
    hit_zero = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (in_key[(KEY_BYTES-1-i)*8 +: 8] == 8'd0) begin
        hit_zero = 1'b1;
      end
      if (!hit_zero) begin
        norm_key[(KEY_BYTES-1-i)*8 +: 8] = in_key[(KEY_BYTES-1-i)*8 +: 8];
      end
    end
  end

  always_comb begin
    if (size_cfg_r == 9'd0) begin
      size_nxt = SW'(1);
    end else if ({23'd0, size_cfg_r} > 32'(DEPTH)) begin
      size_nxt = SW'(DEPTH);
    end else begin
      size_nxt = SW'(size_cfg_r);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_fill) begin
      count_nxt = count_r + 9'd1;
    end else if (cmd.wr_del && count_r != 9'd0) begin
      count_nxt = count_r - 9'd1;
    end
  end

  assign cur_byte = shreg_r[(KEY_BYTES*8)-1 -: 8];
  assign rem_sh = {rem_r, hash_r[63]};
  assign key_we = cmd.wr_fill || cmd.wr_del;
  assign val_we = cmd.wr_fill || cmd.wr_upd || cmd.wr_del;
  assign val_wdata = cmd.wr_del ? 64'd0 : val_r;
  assign st_we = key_we || cmd.wr_upd;
  assign st_wdata = cmd.wr_del ? lphm_pkg::SLOT_DELETED : lphm_pkg::SLOT_OCCUPIED;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= 9'd256;
      count_r <= '0;
      st_valid_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.finish;
      if (cfg_we) begin
        size_cfg_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (st_we) begin
        st_valid_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r <= norm_key;
      shreg_r <= norm_key;
      val_r <= in_value_in;
      hash_r <= '0;
      byte_r <= '0;
      key_end_r <= 1'b0;
      size_r <= size_nxt;
    end
    if (cmd.hash_step) begin
      if (cur_byte == 8'd0) begin
        key_end_r <= 1'b1;
      end else if (!key_end_r) begin
        hash_r <= (hash_r << 5) - hash_r + {{56{cur_byte[7]}}, cur_byte};
      end
      shreg_r <= shreg_r << 8;
      byte_r <= byte_r + BW'(1);
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      bit_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= SW'((rem_sh >= {1'b0, size_r}) ? rem_sh - {1'b0, size_r} : rem_sh);
      hash_r <= hash_r << 1;
      bit_r <= bit_r + DW'(1);
    end
    if (cmd.rd) begin
      vld_rd_r <= st_valid_r[idx_r];
    end
    if (cmd.div_step && bit_r == DW'(63)) begin
      idx_r <= AW'((rem_sh >= {1'b0, size_r}) ? rem_sh - {1'b0, size_r} : rem_sh);
      probes_r <= SW'(1);
    end
    if (cmd.advance) begin
      idx_r <= ({1'b0, idx_r} + SW'(1) == size_r) ? '0 : idx_r + AW'(1);
      probes_r <= probes_r + SW'(1);
    end
    if (cmd.finish) begin
      out_status <= cmd.set_full ? lphm_pkg::STAT_FULL :
                    cmd.set_miss ? lphm_pkg::STAT_MISS : lphm_pkg::STAT_OK;
      out_value_out <= (cmd.set_full || cmd.set_miss || mode_r == lphm_pkg::MODE_PUT) ?
                       64'd0 : val_rd;
      out_entry_count <= count_nxt;
    end
  end

  lphm_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_st_ram (
    .clk(clk), .we(st_we), .addr(idx_r), .wdata(st_wdata), .rdata(st_rd)
  );
  lphm_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .addr(idx_r), .wdata(key_r), .rdata(key_rd)
  );
  lphm_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_val_ram (
    .clk(clk), .we(val_we), .addr(idx_r), .wdata(val_wdata), .rdata(val_rd)
  );

  assign sts.hash_last = (byte_r == BW'(KEY_BYTES - 1));
  assign sts.div_last = (bit_r == DW'(63));
  assign sts.probe_last = (probes_r >= size_r);
  assign sts.slot_st = vld_rd_r ? st_rd : lphm_pkg::SLOT_EMPTY;
  assign sts.key_eq = (key_rd == key_r);
  assign sts.mode = mode_r;

  `ASSERT_NEVER(a_idx_range, clk, rst_n, cmd.rd && ({1'b0, idx_r} >= size_r))
  `ASSERT_NEVER(a_one_write, clk, rst_n, (cmd.wr_fill && cmd.wr_del) || (cmd.wr_upd && cmd.wr_del))
  `ASSERT_NEVER(a_count_max, clk, rst_n, count_r > 9'(DEPTH))
endmodule

FILE: hw/rtl/lphm_ctrl.sv
// ---------------------------------------------------------------------------
// lphm_ctrl
// Sequencer for hash, modulo, probe walk and slot update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lphm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lphm_pkg::lphm_sts_t sts,
  output lphm_pkg::lphm_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_HASH, S_DIV, S_RD, S_WAIT, S_EVAL, S_DONE} state_t;
  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_last) begin
          cmd.div_init = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_DONE;
        if (sts.mode == lphm_pkg::MODE_PUT) begin
          if (sts.slot_st != lphm_pkg::SLOT_OCCUPIED) begin
            cmd.wr_fill = 1'b1;
            cmd.finish = 1'b1;
          end else if (sts.key_eq) begin
            cmd.wr_upd = 1'b1;
            cmd.finish = 1'b1;
          end else if (sts.probe_last) begin
            cmd.finish = 1'b1;
            cmd.set_full = 1'b1;
          end else begin
            cmd.advance = 1'b1;
            state_nxt = S_RD;
          end
        end else if (sts.mode == lphm_pkg::MODE_GET || sts.mode == lphm_pkg::MODE_REMOVE) begin
          if (sts.slot_st == lphm_pkg::SLOT_EMPTY ||
              (sts.slot_st == lphm_pkg::SLOT_DELETED && sts.key_eq)) begin
            cmd.finish = 1'b1;
            cmd.set_miss = 1'b1;
          end else if (sts.slot_st == lphm_pkg::SLOT_OCCUPIED && sts.key_eq) begin
            cmd.finish = 1'b1;
            cmd.wr_del = (sts.mode == lphm_pkg::MODE_REMOVE);
          end else if (sts.probe_last) begin
            cmd.finish = 1'b1;
            cmd.set_miss = 1'b1;
          end else begin
            cmd.advance = 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          cmd.finish = 1'b1;
          cmd.set_miss = 1'b1;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `ASSERT_IMPL(a_start_load, clk, rst_n, (start && !busy) |-> cmd.load)
  `ASSERT_IMPL(a_finish_done, clk, rst_n, cmd.finish |=> (state_r == S_DONE))
  `ASSERT_NEVER(a_finish_idle, clk, rst_n, cmd.finish && state_r != S_EVAL)
endmodule

FILE: hw/rtl/linear_probe_hash_map_top.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_map_top
// Open addressing hash map with linear probing over key and value RAMs.
// ---------------------------------------------------------------------------
// channel | ports                            | handshake
// in      | in_mode, in_key, in_value_in     | start & !busy
// out     | out_status, out_value_out, ...   | out_valid, one cycle
// cfg     | cfg_we, cfg_wdata (table_size)   | cfg_we
// An item hashes its key one byte at a time, reduces the hash in the serial
// modulo unit, then reads each probed slot (S_RD, S_WAIT) and checks it in S_EVAL.
// Reset is synchronous; status bits clear at once, RAMs need no pass.
// Results cannot be stalled; busy holds off new items.
`timescale 1ns / 1ps
module linear_probe_hash_map_top #(
  parameter int KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_value_out,
  output logic [8:0]  out_entry_count
);
  lphm_pkg::lphm_cmd_t cmd;
  lphm_pkg::lphm_sts_t sts;

  lphm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  lphm_datapath #(.KEY_BYTES(KEY_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_mode(in_mode), .in_key(in_key), .in_value_in(in_value_in),
    .cmd(cmd), .sts(sts), .out_valid(out_valid), .out_status(out_status),
    .out_value_out(out_value_out), .out_entry_count(out_entry_count)
  );
endmodule

FILE: bench/linear_probe_hash_map_top_test.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_map_top_test
// Drives get, put, remove and unused-mode requests into the hash map over several table
// sizes and compares every result with a behavioral copy of the table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module linear_probe_hash_map_top_test;
  localparam int DEPTH = lphm_pkg::TABLE_DEPTH;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] value;
    logic [8:0]  count;
  } map_reply_t;

  class map_scoreboard;
    logic [1:0]  slot_state [DEPTH];
    logic [63:0] slot_key [DEPTH];
    logic [63:0] slot_val [DEPTH];
    int unsigned occupied;
    logic [8:0]  size_reg;
    map_reply_t  pending_replies [$];
    int unsigned errors;

    function new();
      for (int i = 0; i < DEPTH; i++) slot_state[i] = lphm_pkg::SLOT_EMPTY;
      occupied = 0;
      size_reg = 9'd256;
      errors = 0;
    endfunction

    function logic [63:0] clean_key(logic [63:0] raw);
      logic [63:0] k;
      logic [7:0] b;
      k = '0;
      for (int i = 0; i < 8; i++) begin
        b = raw[63 - 8 * i -: 8];
        if (b == 8'd0) break;
        k[63 - 8 * i -: 8] = b;
      end
      return k;
    endfunction

    function logic [63:0] key_hash(logic [63:0] k);
      logic [63:0] h;
      logic [7:0] b;
      h = '0;
      for (int i = 0; i < 8; i++) begin
        b = k[63 - 8 * i -: 8];
        if (b == 8'd0) break;
        h = h * 64'd31 + {{56{b[7]}}, b};
      end
      return h;
    endfunction

    function void note_request(logic [1:0] mode, logic [63:0] raw, logic [63:0] vin);
      logic [63:0] k;
      int unsigned sz;
      int unsigned idx;
      map_reply_t r;
      k = clean_key(raw);
      sz = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
      idx = int'(key_hash(k) % 64'(sz));
      r.status = lphm_pkg::STAT_MISS;
      r.value = '0;
      if (mode == lphm_pkg::MODE_PUT) begin
        r.status = lphm_pkg::STAT_FULL;
        for (int n = 0; n < sz; n++) begin
          if (slot_state[idx] != lphm_pkg::SLOT_OCCUPIED) begin
            slot_key[idx] = k;
            slot_val[idx] = vin;
            slot_state[idx] = lphm_pkg::SLOT_OCCUPIED;
            occupied++;
            r.status = lphm_pkg::STAT_OK;
            break;
          end
          if (slot_key[idx] == k) begin
            slot_val[idx] = vin;
            r.status = lphm_pkg::STAT_OK;
            break;
          end
          idx = (idx + 1 == sz) ? 0 : idx + 1;
        end
      end else if (mode == lphm_pkg::MODE_GET || mode == lphm_pkg::MODE_REMOVE) begin
        for (int n = 0; n < sz; n++) begin
          if (slot_state[idx] == lphm_pkg::SLOT_EMPTY) break;
          if (slot_key[idx] == k) begin
            if (slot_state[idx] == lphm_pkg::SLOT_OCCUPIED) begin
              r.value = slot_val[idx];
              r.status = lphm_pkg::STAT_OK;
              if (mode == lphm_pkg::MODE_REMOVE) begin
                slot_val[idx] = '0;
                slot_state[idx] = lphm_pkg::SLOT_DELETED;
                if (occupied > 0) occupied--;
              end
            end
            break;
          end
          idx = (idx + 1 == sz) ? 0 : idx + 1;
        end
      end
      r.count = 9'(occupied);
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] status, logic [63:0] value, logic [8:0] count);
      map_reply_t e;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result status %0d value %h count %0d",
                 $time, status, value, count);
        errors++;
        return;
      end
      e = pending_replies.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
      if (value !== e.value) begin
        $display("%0t: value_out expected %h actual %h", $time, e.value, value);
        errors++;
      end
      if (count !== e.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, e.count, count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = lphm_pkg::MODE_GET;
  logic [63:0] in_key = '0;
  logic [63:0] in_value_in = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [63:0] out_value_out;
  logic [8:0]  out_entry_count;

  map_scoreboard tally = new();
  logic [63:0] key_pool [$];
  int unsigned idle_cycles = 0;

  always #10 clk = ~clk;

  linear_probe_hash_map_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_value_in     (in_value_in),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_value_out   (out_value_out),
    .out_entry_count (out_entry_count)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) tally.check_reply(out_status, out_value_out, out_entry_count);
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("linear_probe_hash_map_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // keys of random length, bytes often above 0x7f; dirty_key adds garbage past the end
  function automatic logic [63:0] make_key();
    logic [63:0] k;
    int unsigned len;
    k = '0;
    len = $urandom_range(0, 8);
    for (int i = 0; i < len; i++) begin
      k[63 - 8 * i -: 8] = 8'($urandom_range(1, 255));
    end
    return k;
  endfunction

  function automatic logic [63:0] dirty_key(logic [63:0] k);
    int unsigned len;
    len = 0;
    while (len < 8 && k[63 - 8 * len -: 8] != 8'd0) len++;
    if (len < 7 && $urandom_range(0, 2) == 0)
      k = k | (rand64() & ((64'd1 << (8 * (7 - len))) - 1));
    return k;
  endfunction

  task automatic send_request(logic [1:0] mode, logic [63:0] key, logic [63:0] vin);
    in_mode <= mode;
    in_key <= key;
    in_value_in <= vin;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    tally.note_request(mode, key, vin);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (tally.pending_replies.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [8:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tally.size_reg = v;
  endtask

  task automatic run_random(int unsigned items, int unsigned pool_len);
    int unsigned burst;
    int unsigned pick;
    logic [1:0] mode;
    logic [63:0] k;
    key_pool.delete();
    for (int i = 0; i < pool_len; i++) key_pool.push_back(make_key());
    burst = 0;
    for (int i = 0; i < items; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end
      end
      burst--;
      pick = $urandom_range(0, 99);
      mode = (pick < 40) ? lphm_pkg::MODE_PUT : (pick < 70) ? lphm_pkg::MODE_GET :
             (pick < 95) ? lphm_pkg::MODE_REMOVE : lphm_pkg::MODE_UNUSED;
      k = ($urandom_range(0, 9) == 0) ? rand64() :
          dirty_key(key_pool[$urandom_range(0, pool_len - 1)]);
      send_request(mode, k, rand64());
      if (i == items / 2 && $urandom_range(0, 1) == 0) drain();
    end
  endtask

  initial begin
    logic [8:0] sizes [11] = '{9'd1, 9'd2, 9'd3, 9'd7, 9'd16, 9'd64, 9'd256,
                               9'd0, 9'd511, 9'd5, 9'd300};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(lphm_pkg::MODE_GET, 64'h0, 64'h0);
    send_request(lphm_pkg::MODE_PUT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(lphm_pkg::MODE_GET, 64'h00AB_CDEF_0000_0001, 64'h0);
    send_request(lphm_pkg::MODE_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    send_request(lphm_pkg::MODE_PUT, 64'h8080_8080_8080_8080, 64'h0);
    send_request(lphm_pkg::MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555);
    send_request(lphm_pkg::MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(lphm_pkg::MODE_REMOVE, 64'h0, 64'h0);
    send_request(lphm_pkg::MODE_GET, 64'h0, 64'h0);
    drain();

    write_size(9'd1);
    send_request(lphm_pkg::MODE_PUT, 64'h4100_0000_0000_0000, 64'h11);
    send_request(lphm_pkg::MODE_PUT, 64'h4100_FFFF_0000_1234, 64'h22);
    send_request(lphm_pkg::MODE_PUT, 64'h4200_0000_0000_0000, 64'h33);
    send_request(lphm_pkg::MODE_GET, 64'h4100_0000_0000_0000, 64'h0);
    send_request(lphm_pkg::MODE_REMOVE, 64'h4100_0000_0000_0000, 64'h0);
    send_request(lphm_pkg::MODE_GET, 64'h4100_0000_0000_0000, 64'h0);
    send_request(lphm_pkg::MODE_REMOVE, 64'h4100_0000_0000_0000, 64'h0);
    send_request(lphm_pkg::MODE_PUT, 64'h4200_0000_0000_0000, 64'h44);
    send_request(lphm_pkg::MODE_GET, 64'h4200_0000_0000_0000, 64'h0);
    drain();

    foreach (sizes[p]) begin
      write_size(sizes[p]);
      run_random(165, (sizes[p] == 0) ? 3 : ((sizes[p] > 64) ? 96 : sizes[p] + 3));
      drain();
    end

    repeat (20) @(posedge clk);
    if (tally.errors == 0 && tally.pending_replies.size() == 0) begin
      $display("linear_probe_hash_map_top verification clean");
    end else begin
      $display("linear_probe_hash_map_top verification failed");
    end
    $finish;
  end
endmodule
